### design/slab_object_allocator_assert.svh
// Assertion macros for the slab object allocator.
`ifndef SLAB_OBJECT_ALLOCATOR_ASSERT_SVH
`define SLAB_OBJECT_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition holds on every clock edge out of reset
`define SOA_ASSERT_HOLDS(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("slab allocator check failed");

// Consequent holds in the same cycle as the antecedent
`define SOA_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("slab allocator check failed");

// Consequent holds in the cycle after the antecedent
`define SOA_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("slab allocator check failed");

`else

`define SOA_ASSERT_HOLDS(label, ck, rn, cond)
`define SOA_ASSERT_IMPL(label, ck, rn, ante, cons)
`define SOA_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

### design/soa_pkg.sv
// Shared types and codes for the slab object allocator.
`timescale 1ns / 1ps

package soa_pkg;

    // Fixed field widths of the request, response and configuration, and the least slot count
    localparam int CHUNK_FIELD_W = 4;
    localparam int SLOT_FIELD_W  = 6;
    localparam int OPC_W         = 7;
    localparam int PRE_W         = 5;
    localparam int CFG_DATA_W    = 7;
    localparam int MIN_SLOTS     = 2;

    // Configuration register indexes
    localparam logic CFG_OBJECTS_PER_CHUNK = 1'b0;
    localparam logic CFG_PREALLOC_CHUNKS   = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2,
        CMD_NOP   = 2'd3
    } soa_cmd_t;

    typedef enum logic [1:0] {
        SC_OK         = 2'd0,
        SC_NO_CHUNK   = 2'd1,
        SC_BAD_HANDLE = 2'd2
    } soa_status_t;

    typedef struct packed {
        soa_cmd_t                 command;
        logic [CHUNK_FIELD_W-1:0] chunk_index;
        logic [SLOT_FIELD_W-1:0]  slot_index;
    } soa_req_t;

    typedef struct packed {
        soa_status_t              status;
        logic [CHUNK_FIELD_W-1:0] granted_chunk;
        logic [SLOT_FIELD_W-1:0]  granted_slot;
    } soa_rsp_t;

    // Write controls for the per-chunk table
    typedef struct packed {
        logic head_we;
        logic fresh_we;
        logic cap_we;
        logic ring_set;
        logic ring_clr;
        logic clear_all;
    } soa_tbl_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_POP,
        S_FREE,
        S_FCHK,
        S_INIT,
        S_MAKE,
        S_DONE
    } soa_state_t;

endpackage

### design/soa_link_ram.sv
// Free-list link memory: one write port, one registered read port.
`timescale 1ns / 1ps

module soa_link_ram #(
    parameter int AW = 10,
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/soa_chunk_table.sv
// Per-chunk state: stack head, fresh count, capacity and deque membership.
`timescale 1ns / 1ps

module soa_chunk_table import soa_pkg::*; #(
    parameter int NUM_CHUNKS = 16,
    parameter int MAX_SLOTS  = 64,
    localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1,
    localparam int KW = $clog2(MAX_SLOTS + 1),
    localparam int LW = $clog2(MAX_SLOTS + 2)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  soa_tbl_ctl_t  ctl,
    input  logic [CW-1:0] wr_idx,
    input  logic [LW-1:0] wr_head,
    input  logic [KW-1:0] wr_fresh,
    input  logic [KW-1:0] wr_cap,
    input  logic [CW-1:0] rd_idx,
    output logic [LW-1:0] rd_head,
    output logic [KW-1:0] rd_fresh,
    output logic [KW-1:0] rd_cap,
    output logic          rd_in_ring
);

    logic [LW-1:0]         head_reg  [NUM_CHUNKS];
    logic [KW-1:0]         fresh_reg [NUM_CHUNKS];
    logic [KW-1:0]         cap_reg   [NUM_CHUNKS];
    logic [NUM_CHUNKS-1:0] in_ring_reg;

    // Payload fields, written when a chunk is made or its list changes
    always_ff @(posedge clk)
    begin
        if (ctl.head_we)
        begin
            head_reg[wr_idx] <= wr_head;
        end
        if (ctl.fresh_we)
        begin
            fresh_reg[wr_idx] <= wr_fresh;
        end
        if (ctl.cap_we)
        begin
            cap_reg[wr_idx] <= wr_cap;
        end
    end

    // Deque membership, cleared by reset and by init
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ring_reg <= '0;
        end
        else if (ctl.clear_all)
        begin
            in_ring_reg <= '0;
        end
        else if (ctl.ring_set)
        begin
            in_ring_reg[wr_idx] <= 1'b1;
        end
        else if (ctl.ring_clr)
        begin
            in_ring_reg[wr_idx] <= 1'b0;
        end
    end

    assign rd_head    = head_reg[rd_idx];
    assign rd_fresh   = fresh_reg[rd_idx];
    assign rd_cap     = cap_reg[rd_idx];
    assign rd_in_ring = in_ring_reg[rd_idx];

endmodule

### design/slab_object_allocator.sv
// Slab object allocator top level: sequencer, partial-chunk deque, config.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------
//  req     | in        | req_valid / req_ready    | soa_req_t (command)
//  rsp     | out       | rsp_valid / rsp_ready    | soa_rsp_t (one result)
//  cfg     | in        | cfg_write (no wait)      | cfg_index, cfg_data
//
// States from accept to next accept, no stall: nop IDLE, DONE; fresh-slot or
// exhausted alloc and range-rejected free add ALLOC or FREE; freed-slot alloc
// adds POP, checked free FCHK; a new chunk repeats ALLOC; init INIT, MAKE.
// Reset clears the control state at once; memories need no clearing pass.
// A stalled response holds in the output register; the sequencer waits in
// its final state until that register frees up.
`timescale 1ns / 1ps
`include "slab_object_allocator_assert.svh"

module slab_object_allocator import soa_pkg::*; #(
    parameter int NUM_CHUNKS = 16,
    parameter int MAX_SLOTS  = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  soa_req_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output soa_rsp_t              rsp,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int NW = $clog2(NUM_CHUNKS + 1);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int KW = $clog2(MAX_SLOTS + 1);
    localparam int LW = $clog2(MAX_SLOTS + 2);
    localparam logic [LW-1:0] LINK_END  = LW'(MAX_SLOTS);
    localparam logic [LW-1:0] LINK_HELD = LW'(MAX_SLOTS + 1);

    soa_state_t     state_reg, state_next;
    logic [OPC_W-1:0] opc_reg;
    logic [PRE_W-1:0] pre_reg;
    logic [NW-1:0]  made_reg, made_next;
    logic [CW-1:0]  front_reg, front_next;
    logic [NW-1:0]  count_reg, count_next;
    logic [NW-1:0]  lim_reg, lim_next;
    logic [CW-1:0]  cur_c_reg, cur_c_next;
    logic [SW-1:0]  cur_s_reg, cur_s_next;
    soa_req_t       req_reg, req_next;
    soa_rsp_t       res_reg, res_next;
    logic           rsp_valid_reg;
    soa_rsp_t       rsp_reg;
    logic           rsp_load;
    logic [CW-1:0]  ring_reg [NUM_CHUNKS];

    logic           ring_we;
    logic [CW-1:0]  ring_waddr;
    logic [CW-1:0]  ring_wdata;
    logic [CW-1:0]  ring_head;

    soa_tbl_ctl_t   tctl;
    logic [CW-1:0]  t_wr_idx;
    logic [LW-1:0]  t_wr_head;
    logic [KW-1:0]  t_wr_fresh;
    logic [CW-1:0]  t_rd_idx;
    logic [LW-1:0]  t_head;
    logic [KW-1:0]  t_fresh;
    logic [KW-1:0]  t_cap;
    logic           t_in_ring;

    logic           l_we;
    logic [CW+SW-1:0] l_waddr;
    logic [LW-1:0]  l_wdata;
    logic           l_re;
    logic [CW+SW-1:0] l_raddr;
    logic [LW-1:0]  l_rdata;

    logic [KW-1:0]  eff_cap;
    logic [CW-1:0]  new_c;
    logic [CW-1:0]  front_dec;
    logic [CW-1:0]  front_inc;
    logic [CW-1:0]  tail_pos;
    int             tail_sum;
    logic [CW-1:0]  req_c;
    logic [SW-1:0]  req_s;
    logic           free_bad;

    // Per-chunk table and link memory
    soa_chunk_table #(
        .NUM_CHUNKS(NUM_CHUNKS),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (tctl),
        .wr_idx    (t_wr_idx),
        .wr_head   (t_wr_head),
        .wr_fresh  (t_wr_fresh),
        .wr_cap    (eff_cap),
        .rd_idx    (t_rd_idx),
        .rd_head   (t_head),
        .rd_fresh  (t_fresh),
        .rd_cap    (t_cap),
        .rd_in_ring(t_in_ring)
    );

    soa_link_ram #(
        .AW(CW + SW),
        .DW(LW)
    ) u_links (
        .clk  (clk),
        .we   (l_we),
        .waddr(l_waddr),
        .wdata(l_wdata),
        .re   (l_re),
        .raddr(l_raddr),
        .rdata(l_rdata)
    );

    // Slots per chunk, clamped to the legal range
    always_comb
    begin
        if (int'(opc_reg) < MIN_SLOTS)
        begin
            eff_cap = KW'(MIN_SLOTS);
        end
        else if (int'(opc_reg) > MAX_SLOTS)
        begin
            eff_cap = KW'(MAX_SLOTS);
        end
        else
        begin
            eff_cap = KW'(opc_reg);
        end
    end

    // Deque pointer arithmetic, modulo the pool size
    assign new_c     = CW'(made_reg);
    assign ring_head = ring_reg[front_reg];
    assign front_dec = (front_reg == '0) ? CW'(NUM_CHUNKS - 1) : CW'(front_reg - 1'b1);
    assign front_inc = (int'(front_reg) == NUM_CHUNKS - 1) ? '0 : CW'(front_reg + 1'b1);
    assign tail_sum  = int'(front_reg) + int'(count_reg);
    assign tail_pos  = (tail_sum >= NUM_CHUNKS) ? CW'(tail_sum - NUM_CHUNKS) : CW'(tail_sum);

    // Handle of the object being freed
    assign req_c    = CW'(req_reg.chunk_index);
    assign req_s    = SW'(req_reg.slot_index);
    assign free_bad = (int'(req_reg.chunk_index) >= int'(made_reg))
                   || (int'(req_reg.slot_index) >= int'(t_cap))
                   || (int'(req_reg.slot_index) >= int'(t_fresh));

    // Sequencer: next state and datapath controls
    always_comb
    begin
        state_next = state_reg;
        made_next  = made_reg;
        front_next = front_reg;
        count_next = count_reg;
        lim_next   = lim_reg;
        cur_c_next = cur_c_reg;
        cur_s_next = cur_s_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        rsp_load   = 1'b0;

        ring_we    = 1'b0;
        ring_waddr = front_dec;
        ring_wdata = new_c;

        tctl       = '0;
        t_wr_idx   = cur_c_reg;
        t_wr_head  = LINK_END;
        t_wr_fresh = '0;
        t_rd_idx   = cur_c_reg;

        l_we       = 1'b0;
        l_waddr    = {cur_c_reg, cur_s_reg};
        l_wdata    = LINK_HELD;
        l_re       = 1'b0;
        l_raddr    = {cur_c_reg, cur_s_reg};

        req_ready  = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    res_next = '{status: SC_OK, granted_chunk: '0, granted_slot: '0};
                    unique case (req.command)
                        CMD_ALLOC: state_next = S_ALLOC;
                        CMD_FREE:  state_next = S_FREE;
                        CMD_INIT:  state_next = S_INIT;
                        CMD_NOP:   state_next = S_DONE;
                        default:   state_next = S_DONE;
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (count_reg == '0)
                begin
                    if (int'(made_reg) >= NUM_CHUNKS)
                    begin
                        res_next.status = SC_NO_CHUNK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // Make a chunk at the deque front, then retry
                        tctl.head_we  = 1'b1;
                        tctl.fresh_we = 1'b1;
                        tctl.cap_we   = 1'b1;
                        tctl.ring_set = 1'b1;
                        t_wr_idx      = new_c;
                        ring_we       = 1'b1;
                        front_next    = front_dec;
                        made_next     = made_reg + 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                else
                begin
                    t_rd_idx   = ring_head;
                    cur_c_next = ring_head;
                    if (t_head < LINK_END)
                    begin
                        // Pop a freed slot: fetch its link first
                        cur_s_next = SW'(t_head);
                        l_re       = 1'b1;
                        l_raddr    = {ring_head, SW'(t_head)};
                        state_next = S_POP;
                    end
                    else
                    begin
                        // Take the next fresh slot
                        l_we          = 1'b1;
                        l_waddr       = {ring_head, SW'(t_fresh)};
                        tctl.fresh_we = 1'b1;
                        t_wr_idx      = ring_head;
                        t_wr_fresh    = KW'(t_fresh + 1'b1);
                        if (int'(t_fresh) + 1 >= int'(t_cap))
                        begin
                            tctl.ring_clr = 1'b1;
                            front_next    = front_inc;
                            count_next    = count_reg - 1'b1;
                        end
                        res_next.granted_chunk = CHUNK_FIELD_W'(ring_head);
                        res_next.granted_slot  = SLOT_FIELD_W'(SW'(t_fresh));
                        state_next             = S_DONE;
                    end
                end
            end

            S_POP:
            begin
                tctl.head_we = 1'b1;
                t_wr_head    = l_rdata;
                l_we         = 1'b1;
                if ((l_rdata >= LINK_END) && (int'(t_fresh) >= int'(t_cap)))
                begin
                    tctl.ring_clr = 1'b1;
                    front_next    = front_inc;
                    count_next    = count_reg - 1'b1;
                end
                res_next.granted_chunk = CHUNK_FIELD_W'(cur_c_reg);
                res_next.granted_slot  = SLOT_FIELD_W'(cur_s_reg);
                state_next             = S_DONE;
            end

            S_FREE:
            begin
                t_rd_idx   = req_c;
                cur_c_next = req_c;
                cur_s_next = req_s;
                if (free_bad)
                begin
                    res_next.status = SC_BAD_HANDLE;
                    state_next      = S_DONE;
                end
                else
                begin
                    l_re       = 1'b1;
                    l_raddr    = {req_c, req_s};
                    state_next = S_FCHK;
                end
            end

            S_FCHK:
            begin
                if (l_rdata != LINK_HELD)
                begin
                    // Slot not allocated: double free or stale handle
                    res_next.status = SC_BAD_HANDLE;
                end
                else
                begin
                    if (!t_in_ring)
                    begin
                        ring_we       = 1'b1;
                        ring_waddr    = tail_pos;
                        ring_wdata    = cur_c_reg;
                        tctl.ring_set = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                    l_we         = 1'b1;
                    l_wdata      = t_head;
                    tctl.head_we = 1'b1;
                    t_wr_head    = LW'(cur_s_reg);
                end
                state_next = S_DONE;
            end

            S_INIT:
            begin
                made_next      = '0;
                front_next     = '0;
                count_next     = '0;
                tctl.clear_all = 1'b1;
                if (int'(pre_reg) > NUM_CHUNKS)
                begin
                    lim_next        = NW'(NUM_CHUNKS);
                    res_next.status = SC_NO_CHUNK;
                end
                else
                begin
                    lim_next = NW'(pre_reg);
                end
                state_next = S_MAKE;
            end

            S_MAKE:
            begin
                if (made_reg < lim_reg)
                begin
                    tctl.head_we  = 1'b1;
                    tctl.fresh_we = 1'b1;
                    tctl.cap_we   = 1'b1;
                    tctl.ring_set = 1'b1;
                    t_wr_idx      = new_c;
                    ring_we       = 1'b1;
                    front_next    = front_dec;
                    made_next     = made_reg + 1'b1;
                    count_next    = count_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            made_reg      <= '0;
            front_reg     <= '0;
            count_reg     <= '0;
            lim_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            made_reg  <= made_next;
            front_reg <= front_next;
            count_reg <= count_next;
            lim_reg   <= lim_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opc_reg <= OPC_W'(64);
            pre_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_OBJECTS_PER_CHUNK: opc_reg <= cfg_data[OPC_W-1:0];
                CFG_PREALLOC_CHUNKS:   pre_reg <= cfg_data[PRE_W-1:0];
                default:               pre_reg <= pre_reg;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_c_reg <= cur_c_next;
        cur_s_reg <= cur_s_next;
        req_reg   <= req_next;
        res_reg   <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
        if (ring_we)
        begin
            ring_reg[ring_waddr] <= ring_wdata;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `SOA_ASSERT_HOLDS(a_ring_le_made, clk, rst_n, int'(count_reg) <= int'(made_reg))
    `SOA_ASSERT_HOLDS(a_made_le_pool, clk, rst_n, int'(made_reg) <= NUM_CHUNKS)
    `SOA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, state_reg != S_IDLE)
    `SOA_ASSERT_IMPL(a_fail_no_grant, clk, rst_n, rsp_valid && (rsp.status != SC_OK),
        (rsp.granted_chunk == '0) && (rsp.granted_slot == '0))

endmodule

### dv/tb_top.sv
// Self-checking testbench for the slab object allocator: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
    import soa_pkg::*;

    localparam int NCH        = 16;
    localparam int NSL        = 64;
    localparam int LINK_END   = NSL;
    localparam int LINK_HELD  = NSL + 1;
    localparam int CYCLE_CAP  = 300000;
    localparam int SETTLE_CYC = 8;

    typedef struct packed {
        logic [3:0] ch;
        logic [5:0] sl;
    } obj_handle_t;

    // DUT connections
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    soa_req_t              req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    soa_rsp_t              rsp;
    logic                  cfg_write = 1'b0;
    logic                  cfg_index = CFG_OBJECTS_PER_CHUNK;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Allocator shadow state
    logic [6:0] link_mem  [NCH*NSL] = '{default: '0};
    logic [6:0] head_of   [NCH]     = '{default: '0};
    logic [6:0] fresh_of  [NCH]     = '{default: '0};
    logic [6:0] cap_of    [NCH]     = '{default: '0};
    logic [3:0] ring_slot [NCH]     = '{default: '0};
    bit         on_ring   [NCH]     = '{default: 1'b0};
    int         made_cnt  = 0;
    int         ring_head = 0;
    int         ring_cnt  = 0;
    logic [6:0] shadow_opc = 7'd64;
    logic [4:0] shadow_pre = 5'd0;

    soa_rsp_t    pending_grants [$];
    obj_handle_t live_objs [$];
    int          mismatch_cnt = 0;
    int          cycle_cnt    = 0;
    bit          steady       = 1'b0;

    slab_object_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle cycles before a request or after a response; none in steady stretches
    function int draw_gap();
        return steady ? 0 : $urandom_range(0, 10);
    endfunction

    // New chunk goes to the front of the partial deque
    function automatic void make_chunk();
        int c;
        c = made_cnt;
        head_of[c]  = 7'(LINK_END);
        fresh_of[c] = '0;
        cap_of[c]   = (shadow_opc < 2) ? 7'd2 : (shadow_opc > NSL) ? 7'(NSL) : shadow_opc;
        made_cnt++;
        ring_head = (ring_head + NCH - 1) % NCH;
        ring_slot[ring_head] = 4'(c);
        ring_cnt++;
        on_ring[c] = 1'b1;
    endfunction

    // Expected grant for one accepted request; updates the shadow state
    function automatic soa_rsp_t predict_grant(input soa_req_t r);
        soa_rsp_t g;
        int c, s, n;
        g = '0;
        g.status = SC_OK;
        case (r.command)
            CMD_ALLOC: begin
                if (ring_cnt == 0 && made_cnt >= NCH) begin
                    g.status = SC_NO_CHUNK;
                end else begin
                    if (ring_cnt == 0)
                        make_chunk();
                    c = ring_slot[ring_head];
                    if (head_of[c] < NSL) begin
                        s = head_of[c];
                        head_of[c] = link_mem[c*NSL + s];
                    end else begin
                        s = fresh_of[c] % NSL;
                        fresh_of[c] = fresh_of[c] + 7'd1;
                    end
                    link_mem[c*NSL + s] = 7'(LINK_HELD);
                    // chunk is full: drop it from the deque
                    if (head_of[c] >= NSL && fresh_of[c] >= cap_of[c]) begin
                        ring_head = (ring_head + 1) % NCH;
                        ring_cnt--;
                        on_ring[c] = 1'b0;
                    end
                    g.granted_chunk = 4'(c);
                    g.granted_slot  = 6'(s);
                end
            end
            CMD_FREE: begin
                c = r.chunk_index;
                s = r.slot_index;
                if (c >= made_cnt || s >= cap_of[c] || s >= fresh_of[c] ||
                    link_mem[c*NSL + s] != LINK_HELD) begin
                    g.status = SC_BAD_HANDLE;
                end else begin
                    // a full chunk rejoins at the tail
                    if (!on_ring[c]) begin
                        ring_slot[(ring_head + ring_cnt) % NCH] = 4'(c);
                        ring_cnt++;
                        on_ring[c] = 1'b1;
                    end
                    link_mem[c*NSL + s] = head_of[c];
                    head_of[c] = 7'(s);
                end
            end
            CMD_INIT: begin
                n = shadow_pre;
                made_cnt  = 0;
                ring_head = 0;
                ring_cnt  = 0;
                for (int i = 0; i < NCH; i++) begin
                    on_ring[i] = 1'b0;
                    cap_of[i]  = '0;
                end
                if (n > NCH) begin
                    n = NCH;
                    g.status = SC_NO_CHUNK;
                end
                for (int i = 0; i < n; i++)
                    make_chunk();
            end
            default: ;
        endcase
        return g;
    endfunction

    // Send one request; valid stays up so a back-to-back request needs no gap
    task automatic send_req(input soa_cmd_t cmd, input int ch, input int sl);
        int       gap;
        soa_req_t item;
        soa_rsp_t g;
        gap = draw_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.command     = cmd;
        item.chunk_index = 4'(ch);
        item.slot_index  = 6'(sl);
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        g = predict_grant(item);
        pending_grants.push_back(g);
        // track handles currently held so random frees can return them
        if (cmd == CMD_ALLOC && g.status == SC_OK) begin
            live_objs.push_back({g.granted_chunk, g.granted_slot});
        end else if (cmd == CMD_FREE && g.status == SC_OK) begin
            for (int i = 0; i < live_objs.size(); i++) begin
                if (live_objs[i] == {item.chunk_index, item.slot_index}) begin
                    live_objs.delete(i);
                    break;
                end
            end
        end else if (cmd == CMD_INIT) begin
            live_objs.delete();
        end
    endtask

    // Drop valid and wait until every expected response is back
    task automatic settle();
        req_valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Write both registers; only called with the block idle
    task automatic set_cfg(input int opc, input int pre);
        cfg_write <= 1'b1;
        cfg_index <= CFG_OBJECTS_PER_CHUNK;
        cfg_data  <= CFG_DATA_W'(opc);
        @(posedge clk);
        shadow_opc = 7'(opc);
        cfg_index <= CFG_PREALLOC_CHUNKS;
        cfg_data  <= CFG_DATA_W'(pre);
        @(posedge clk);
        shadow_pre = 5'(pre);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_alloc_free();
        send_req(CMD_NOP, 15, 63);
        send_req(CMD_ALLOC, 0, 0);
        send_req(CMD_ALLOC, 15, 63);
        send_req(CMD_FREE, 0, 1);
        send_req(CMD_ALLOC, 0, 0);
    endtask

    task automatic test_bad_handles();
        send_req(CMD_FREE, 15, 0);
        send_req(CMD_FREE, 0, 1);
        send_req(CMD_FREE, 0, 1);
        send_req(CMD_FREE, 0, 63);
        send_req(CMD_FREE, 0, 2);
    endtask

    task automatic test_init_clamp();
        // oversize chunk setting, too many preallocated chunks
        settle();
        set_cfg(127, 31);
        send_req(CMD_INIT, 0, 0);
        send_req(CMD_ALLOC, 0, 0);
        send_req(CMD_FREE, 15, 0);
        // undersize chunk setting: chunks fill after two objects
        settle();
        set_cfg(0, 1);
        send_req(CMD_INIT, 15, 63);
        send_req(CMD_ALLOC, 0, 0);
        send_req(CMD_ALLOC, 0, 0);
        send_req(CMD_FREE, 0, 2);
        send_req(CMD_ALLOC, 0, 0);
        send_req(CMD_FREE, 0, 0);
        send_req(CMD_ALLOC, 0, 0);
        send_req(CMD_ALLOC, 0, 0);
        settle();
        set_cfg(64, 0);
        send_req(CMD_INIT, 0, 0);
        send_req(CMD_ALLOC, 0, 0);
    endtask

    task automatic test_random_traffic();
        int          roll, alloc_pct, opc, pre, idx;
        obj_handle_t h;
        for (int phase = 0; phase < 7; phase++) begin
            alloc_pct = 50;
            case (phase)
                0: begin opc = 2;   pre = 16; alloc_pct = 70; end
                1: begin opc = 64;  pre = 0;  end
                2: begin opc = 0;   pre = 31; alloc_pct = 65; end
                3: begin opc = 127; pre = $urandom_range(0, 16); end
                4: begin opc = $urandom_range(2, 8); pre = $urandom_range(0, 4); end
                5: begin opc = $urandom_range(0, 127); pre = $urandom_range(0, 127); end
                default: begin opc = $urandom_range(3, 12); pre = 0; alloc_pct = 60; end
            endcase
            settle();
            set_cfg(opc, pre);
            if (phase != 6)
                send_req(CMD_INIT, $urandom_range(0, 15), $urandom_range(0, 63));
            for (int i = 0; i < 130; i++) begin
                if (i % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                roll = $urandom_range(0, 99);
                if (roll < alloc_pct) begin
                    send_req(CMD_ALLOC, $urandom_range(0, 15), $urandom_range(0, 63));
                end else if (roll < 88 && live_objs.size() != 0) begin
                    idx = $urandom_range(0, live_objs.size() - 1);
                    h = live_objs[idx];
                    send_req(CMD_FREE, h.ch, h.sl);
                end else begin
                    // noise: any command with any handle
                    send_req(soa_cmd_t'($urandom_range(0, 3)),
                             $urandom_range(0, 15), $urandom_range(0, 63));
                end
            end
            steady = 1'b0;
        end
    endtask

    // Response ready with random stalls after each response
    always @(posedge clk) begin : rsp_stall
        int n;
        int rsp_hold;
        if (!rst_n) begin
            rsp_ready <= 1'b0;
            rsp_hold = 0;
        end else if (rsp_valid && rsp_ready) begin
            n = draw_gap();
            rsp_hold = n;
            rsp_ready <= (n == 0);
        end else if (rsp_hold > 0) begin
            rsp_hold = rsp_hold - 1;
            rsp_ready <= (rsp_hold == 0);
        end else begin
            rsp_ready <= 1'b1;
        end
    end

    // Compare each response with the oldest expected grant
    always @(posedge clk) begin : rsp_check
        soa_rsp_t exp_g;
        if (rst_n && rsp_valid && rsp_ready) begin
            if (pending_grants.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: response with none expected: status=%0d chunk=%0d slot=%0d",
                             $time, rsp.status, rsp.granted_chunk, rsp.granted_slot);
            end else begin
                exp_g = pending_grants.pop_front();
                if (rsp.status !== exp_g.status || rsp.granted_chunk !== exp_g.granted_chunk ||
                    rsp.granted_slot !== exp_g.granted_slot) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: mismatch exp status=%0d chunk=%0d slot=%0d, got status=%0d chunk=%0d slot=%0d",
                                 $time, exp_g.status, exp_g.granted_chunk, exp_g.granted_slot,
                                 rsp.status, rsp.granted_chunk, rsp.granted_slot);
                end
            end
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_alloc_free();
        test_bad_handles();
        test_init_clamp();
        test_random_traffic();
        settle();
        if (mismatch_cnt == 0 && pending_grants.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/soa_pkg.sv
design/soa_link_ram.sv
design/soa_chunk_table.sv
design/slab_object_allocator.sv
dv/tb_top.sv
